### hw/rtl/uds_ascii_hex_response_parser_core_defines.svh
// ----------------------------------------------------------------------------
// uds ascii hex response parser assertion macros
// concurrent assertion helpers used by the rtl core of the parser
// ----------------------------------------------------------------------------
`ifndef UDS_ASCII_HEX_RESPONSE_PARSER_CORE_DEFINES_SVH
`define UDS_ASCII_HEX_RESPONSE_PARSER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define UDS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("uds parser assertion failed");
`define UDS_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("uds parser forbidden condition");
`else
`define UDS_ASSERT(name, clk, rst_n, prop)
`define UDS_ASSERT_NEVER(name, clk, rst_n, prop)
`endif

`endif

### hw/rtl/uds_ahrp_pkg.sv
// ----------------------------------------------------------------------------
// uds ascii hex response parser package
// constants, codes, result item type and hex decode helpers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uds_ahrp_pkg;

  localparam logic [5:0] CollectDepth = 6'd32;
  localparam logic [4:0] MaxPayload   = 5'd29;
  localparam logic [7:0] SidPositive  = 8'h62;
  localparam logic [7:0] SidNegative  = 8'h7F;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);
  localparam int unsigned FifoCw    = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    StatusOk,
    StatusNoResponse,
    StatusNegative,
    StatusTooShort,
    StatusDidMismatch,
    StatusNoData
  } status_e;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] data_byte;
    status_e    status;
    logic [7:0] nrc;
    logic [4:0] payload_length;
    logic       end_of_run;
  } out_item_t;

  function automatic logic is_hex(logic [7:0] c);
    is_hex = ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [7:0] diff;
    if (c <= 8'h39) begin
      diff = c - 8'h30;
    end else if (c >= 8'h61) begin
      diff = c - 8'h57;
    end else begin
      diff = c - 8'h37;
    end
    hex_nibble = diff[3:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/uds_ascii_hex_response_parser_core.sv
// ----------------------------------------------------------------------------
// uds ascii hex response parser core
// turns an adapter's ascii reply into payload bytes and one status item
// ----------------------------------------------------------------------------
// a result is held in the input register and then in the result queue before it leaves
// throughput: one character per cycle while the result queue has room for two more items,
//   set by the input register and the parse step into a 4-entry result queue
// a final character may push a payload item and a status item together
// reset: all parse state and queue cleared, expected_did set to 0
`timescale 1ns / 1ps
`default_nettype none
`include "uds_ascii_hex_response_parser_core_defines.svh"

module uds_ascii_hex_response_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,     // expected_did
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // ch[7:0]
  input  wire logic        s_axis_tlast,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // data_byte[7:0], status[10:8], nrc[18:11],
                                           // payload_length[23:19]
  output      logic        m_axis_tuser,   // item_kind
  output      logic        m_axis_tlast
);

  localparam logic [uds_ahrp_pkg::FifoCw-1:0] FifoRoomLimit =
    uds_ahrp_pkg::FifoCw'(uds_ahrp_pkg::FifoDepth - 2);
  localparam logic [uds_ahrp_pkg::FifoCw-1:0] FifoFull =
    uds_ahrp_pkg::FifoCw'(uds_ahrp_pkg::FifoDepth);

  logic [15:0] expected_did_q;

  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;

  logic [1:0] digit_run_q, digit_run_d;
  logic [3:0] first_nibble_q, first_nibble_d;
  logic [3:0] second_nibble_q, second_nibble_d;
  logic [5:0] bytes_collected_q, bytes_collected_d;
  logic [5:0] response_index_q, response_index_d;
  logic       service_found_q, service_found_d;
  logic       reply_negative_q, reply_negative_d;
  logic       echo_ok_q, echo_ok_d;
  logic [7:0] held_nrc_q, held_nrc_d;
  logic [4:0] payload_count_q, payload_count_d;

  uds_ahrp_pkg::out_item_t fifo_q [uds_ahrp_pkg::FifoDepth];
  logic [uds_ahrp_pkg::FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [uds_ahrp_pkg::FifoAw-1:0] wr_ptr_nx;
  logic [uds_ahrp_pkg::FifoCw-1:0] count_q;

  logic                    proc_fire;
  logic                    pop;
  logic                    ch_hex;
  logic [3:0]              ch_nib;
  logic                    take;
  logic [7:0]              take_b;
  logic                    emit;
  uds_ahrp_pkg::status_e   st;
  logic [7:0]              st_nrc;
  logic [4:0]              st_len;
  uds_ahrp_pkg::out_item_t pay_item, st_item;
  uds_ahrp_pkg::out_item_t head;

  assign cfg_ready_o   = 1'b1;
  assign proc_fire     = in_valid_q && (count_q <= FifoRoomLimit);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_nx     = wr_ptr_q + 1'b1;

  assign ch_hex = uds_ahrp_pkg::is_hex(in_ch_q);
  assign ch_nib = uds_ahrp_pkg::hex_nibble(in_ch_q);

  always_comb begin
    digit_run_d       = digit_run_q;
    first_nibble_d    = first_nibble_q;
    second_nibble_d   = second_nibble_q;
    bytes_collected_d = bytes_collected_q;
    response_index_d  = response_index_q;
    service_found_d   = service_found_q;
    reply_negative_d  = reply_negative_q;
    echo_ok_d         = echo_ok_q;
    held_nrc_d        = held_nrc_q;
    payload_count_d   = payload_count_q;
    take              = 1'b0;
    take_b            = {first_nibble_q, second_nibble_q};
    emit              = 1'b0;
    st                = uds_ahrp_pkg::StatusOk;
    st_nrc            = 8'h00;
    st_len            = 5'd0;

    if (bytes_collected_q < uds_ahrp_pkg::CollectDepth) begin
      if (ch_hex) begin
        case (digit_run_q)
          2'd0:    first_nibble_d = ch_nib;
          2'd1:    second_nibble_d = ch_nib;
          default: ;
        endcase
        if (digit_run_q != 2'd3) begin
          digit_run_d = digit_run_q + 2'd1;
        end
        if (in_last_q && (digit_run_q == 2'd1)) begin
          take   = 1'b1;
          take_b = {first_nibble_q, ch_nib};
        end
      end else begin
        take        = (digit_run_q == 2'd2);
        digit_run_d = 2'd0;
      end
    end

    if (take) begin
      if (bytes_collected_q != 6'd63) begin
        bytes_collected_d = bytes_collected_q + 6'd1;
      end
      if (!service_found_q) begin
        if ((take_b == uds_ahrp_pkg::SidPositive) || (take_b == uds_ahrp_pkg::SidNegative)) begin
          service_found_d  = 1'b1;
          reply_negative_d = (take_b == uds_ahrp_pkg::SidNegative);
          response_index_d = 6'd1;
        end
      end else begin
        if (reply_negative_q) begin
          if (response_index_q == 6'd2) begin
            held_nrc_d = take_b;
          end
        end else if (response_index_q == 6'd1) begin
          if (take_b != expected_did_q[15:8]) begin
            echo_ok_d = 1'b0;
          end
        end else if (response_index_q == 6'd2) begin
          if (take_b != expected_did_q[7:0]) begin
            echo_ok_d = 1'b0;
          end
        end else if (echo_ok_q && (payload_count_q < uds_ahrp_pkg::MaxPayload)) begin
          emit            = 1'b1;
          payload_count_d = payload_count_q + 5'd1;
        end
        if (response_index_q != 6'd63) begin
          response_index_d = response_index_q + 6'd1;
        end
      end
    end

    if (!service_found_d) begin
      st = uds_ahrp_pkg::StatusNoResponse;
    end else if (reply_negative_d) begin
      st     = uds_ahrp_pkg::StatusNegative;
      st_nrc = held_nrc_d;
    end else if (response_index_d < 6'd3) begin
      st = uds_ahrp_pkg::StatusTooShort;
    end else if (!echo_ok_d) begin
      st = uds_ahrp_pkg::StatusDidMismatch;
    end else if (response_index_d < 6'd4) begin
      st = uds_ahrp_pkg::StatusNoData;
    end else begin
      st     = uds_ahrp_pkg::StatusOk;
      st_len = payload_count_d;
    end

    if (in_last_q) begin
      digit_run_d       = 2'd0;
      first_nibble_d    = 4'h0;
      second_nibble_d   = 4'h0;
      bytes_collected_d = 6'd0;
      response_index_d  = 6'd0;
      service_found_d   = 1'b0;
      reply_negative_d  = 1'b0;
      echo_ok_d         = 1'b1;
      held_nrc_d        = 8'h00;
      payload_count_d   = 5'd0;
    end
  end

  always_comb begin
    pay_item                = '0;
    pay_item.item_kind      = 1'b0;
    pay_item.data_byte      = take_b;
    pay_item.status         = uds_ahrp_pkg::StatusOk;
    st_item                 = '0;
    st_item.item_kind       = 1'b1;
    st_item.status          = st;
    st_item.nrc             = st_nrc;
    st_item.payload_length  = st_len;
    st_item.end_of_run      = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_did_q    <= 16'h0000;
      in_valid_q        <= 1'b0;
      digit_run_q       <= 2'd0;
      first_nibble_q    <= 4'h0;
      second_nibble_q   <= 4'h0;
      bytes_collected_q <= 6'd0;
      response_index_q  <= 6'd0;
      service_found_q   <= 1'b0;
      reply_negative_q  <= 1'b0;
      echo_ok_q         <= 1'b1;
      held_nrc_q        <= 8'h00;
      payload_count_q   <= 5'd0;
      wr_ptr_q          <= '0;
      rd_ptr_q          <= '0;
      count_q           <= '0;
    end else begin
      if (cfg_valid_i) begin
        expected_did_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc_fire) begin
        digit_run_q       <= digit_run_d;
        first_nibble_q    <= first_nibble_d;
        second_nibble_q   <= second_nibble_d;
        bytes_collected_q <= bytes_collected_d;
        response_index_q  <= response_index_d;
        service_found_q   <= service_found_d;
        reply_negative_q  <= reply_negative_d;
        echo_ok_q         <= echo_ok_d;
        held_nrc_q        <= held_nrc_d;
        payload_count_q   <= payload_count_d;
      end
      if (proc_fire) begin
        wr_ptr_q <= wr_ptr_q + uds_ahrp_pkg::FifoAw'({1'b0, emit} + {1'b0, in_last_q});
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q
               + uds_ahrp_pkg::FifoCw'(proc_fire && emit)
               + uds_ahrp_pkg::FifoCw'(proc_fire && in_last_q)
               - uds_ahrp_pkg::FifoCw'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (proc_fire) begin
      if (emit) begin
        fifo_q[wr_ptr_q] <= pay_item;
        if (in_last_q) begin
          fifo_q[wr_ptr_nx] <= st_item;
        end
      end else if (in_last_q) begin
        fifo_q[wr_ptr_q] <= st_item;
      end
    end
  end

  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = {head.payload_length, head.nrc, head.status, head.data_byte};
  assign m_axis_tuser  = head.item_kind;
  assign m_axis_tlast  = head.end_of_run;

  `UDS_ASSERT(a_fifo_bound, clk_i, rst_ni, count_q <= FifoFull)
  `UDS_ASSERT(a_payload_cap, clk_i, rst_ni, payload_count_q <= uds_ahrp_pkg::MaxPayload)
  `UDS_ASSERT(a_clear_after_last, clk_i, rst_ni,
    (proc_fire && in_last_q) |=> (bytes_collected_q == 6'd0) && !service_found_q)
  `UDS_ASSERT_NEVER(a_status_without_eor, clk_i, rst_ni,
    m_axis_tvalid && (m_axis_tuser != m_axis_tlast))

endmodule

`default_nettype wire
